// ===== hw/rtl/isad_pkg.sv =====
// ----------------------------------------------------------------------------
// isad_pkg
// Shared types and codes for the indexed shift-array deque.
// ----------------------------------------------------------------------------
package isad_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_ENTRY_WIDTH = 32;

  localparam logic [3:0] REQ_GET        = 4'd0;
  localparam logic [3:0] REQ_SET        = 4'd1;
  localparam logic [3:0] REQ_INSERT     = 4'd2;
  localparam logic [3:0] REQ_REMOVE     = 4'd3;
  localparam logic [3:0] REQ_PUSH_BACK  = 4'd4;
  localparam logic [3:0] REQ_PUSH_FRONT = 4'd5;
  localparam logic [3:0] REQ_POP_FRONT  = 4'd6;
  localparam logic [3:0] REQ_POP_BACK   = 4'd7;
  localparam logic [3:0] REQ_LOOK_FRONT = 4'd8;
  localparam logic [3:0] REQ_LOOK_BACK  = 4'd9;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADIDX = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [6:0]  position;
    logic [31:0] entry_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  result_index;
    logic [31:0] entry_out;
    logic [6:0]  count_out;
    logic        is_empty;
  } rsp_t;

endpackage

// ===== hw/rtl/indexed_shift_array_deque_core.sv =====
// ----------------------------------------------------------------------------
// indexed_shift_array_deque_core
// Ordered list of entry handles in a single-port-write memory, edited by a
// small sequencer that moves one entry at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_stall stays high until its result is
// loaded into the output register. Get, set, look and pop back move no entries.
// Insert and the pushes shift the entries at and above the index up by one,
// remove and pop front shift the entries above it down by one (pop front after
// a read of the popped entry): every shifted entry costs one memory read and
// one memory write through the single write port of the entry memory. The
// result register frees the input side while a result waits to be taken. No
// clearing pass is needed after reset.
module indexed_shift_array_deque_core #(
  parameter int CAPACITY    = isad_pkg::DEF_CAPACITY,
  parameter int ENTRY_WIDTH = isad_pkg::DEF_ENTRY_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  isad_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output isad_pkg::rsp_t rsp
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_FETCHD, S_SHRD, S_SHWR, S_OUT
  } state_t;

  typedef enum logic [1:0] {M_NONE, M_UP, M_DOWN} mode_t;

  state_t                 state;
  mode_t                  mode;
  logic [CW-1:0]          count;
  logic [CW-1:0]          ptr;
  logic [CW-1:0]          stop;
  logic [AW-1:0]          fetch_addr;
  logic [ENTRY_WIDTH-1:0] val;
  logic [ENTRY_WIDTH-1:0] eout;
  logic [CW-1:0]          ridx;
  logic [1:0]             status;

  logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_data;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [ENTRY_WIDTH-1:0] wr_data;

  logic                   accept;
  logic                   out_free;
  logic [CMPW-1:0]        posx;
  logic [CMPW-1:0]        cntx;
  logic                   full;
  logic                   empty;
  logic [CW-1:0]          pos_c;
  logic [CW-1:0]          last;
  logic [63:0]            wide_in;
  logic [ENTRY_WIDTH-1:0] val_in;
  logic [63:0]            wide_out;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign posx      = CMPW'(req.position);
  assign cntx      = CMPW'(count);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign pos_c     = CW'(req.position);
  assign last      = count - CW'(1);
  assign wide_in   = 64'(req.entry_in);
  assign val_in    = wide_in[ENTRY_WIDTH-1:0];
  assign wide_out  = 64'(eout);

  always_comb begin
    rd_addr = fetch_addr;
    wr_en   = 1'b0;
    wr_addr = ptr[AW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_SHRD: begin
        if (mode == M_UP) begin
          rd_addr = AW'(ptr - CW'(1));
          if (ptr == stop) begin
            wr_en   = 1'b1;
            wr_data = val;
          end
        end else begin
          rd_addr = AW'(ptr + CW'(1));
        end
      end
      S_SHWR: begin
        wr_en = 1'b1;
      end
      default: begin
        rd_addr = fetch_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      mode      <= M_NONE;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status     <= isad_pkg::ST_OK;
            ridx       <= '0;
            eout       <= '0;
            val        <= val_in;
            mode       <= M_NONE;
            fetch_addr <= '0;
            ptr        <= count;
            stop       <= '0;
            state      <= S_OUT;
            case (req.req_type)
              isad_pkg::REQ_GET: begin
                if (posx < cntx) begin
                  ridx       <= pos_c;
                  fetch_addr <= AW'(pos_c);
                  state      <= S_FETCH;
                end else begin
                  status <= isad_pkg::ST_BADIDX;
                end
              end
              isad_pkg::REQ_SET: begin
                if (posx < cntx) begin
                  ridx  <= pos_c;
                  mode  <= M_UP;
                  ptr   <= pos_c;
                  stop  <= pos_c;
                  state <= S_SHRD;
                end else begin
                  status <= isad_pkg::ST_BADIDX;
                end
              end
              isad_pkg::REQ_INSERT: begin
                if (posx > cntx) begin
                  status <= isad_pkg::ST_BADIDX;
                end else if (full) begin
                  status <= isad_pkg::ST_FULL;
                end else begin
                  ridx  <= pos_c;
                  mode  <= M_UP;
                  stop  <= pos_c;
                  count <= count + CW'(1);
                  state <= S_SHRD;
                end
              end
              isad_pkg::REQ_REMOVE: begin
                if (posx < cntx) begin
                  ridx  <= pos_c;
                  mode  <= M_DOWN;
                  ptr   <= pos_c;
                  stop  <= last;
                  count <= last;
                  state <= S_SHRD;
                end else begin
                  status <= isad_pkg::ST_BADIDX;
                end
              end
              isad_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                  status <= isad_pkg::ST_FULL;
                end else begin
                  ridx  <= count;
                  mode  <= M_UP;
                  stop  <= count;
                  count <= count + CW'(1);
                  state <= S_SHRD;
                end
              end
              isad_pkg::REQ_PUSH_FRONT: begin
                if (full) begin
                  status <= isad_pkg::ST_FULL;
                end else begin
                  mode  <= M_UP;
                  count <= count + CW'(1);
                  state <= S_SHRD;
                end
              end
              isad_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                  status <= isad_pkg::ST_EMPTY;
                end else begin
                  mode  <= M_DOWN;
                  ptr   <= '0;
                  stop  <= last;
                  count <= last;
                  state <= S_FETCH;
                end
              end
              isad_pkg::REQ_POP_BACK: begin
                if (empty) begin
                  status <= isad_pkg::ST_EMPTY;
                end else begin
                  ridx       <= last;
                  fetch_addr <= AW'(last);
                  count      <= last;
                  state      <= S_FETCH;
                end
              end
              isad_pkg::REQ_LOOK_FRONT: begin
                if (empty) begin
                  status <= isad_pkg::ST_EMPTY;
                end else begin
                  state <= S_FETCH;
                end
              end
              isad_pkg::REQ_LOOK_BACK: begin
                if (empty) begin
                  status <= isad_pkg::ST_EMPTY;
                end else begin
                  ridx       <= last;
                  fetch_addr <= AW'(last);
                  state      <= S_FETCH;
                end
              end
              default: begin
                status <= isad_pkg::ST_OK;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_FETCHD;
        end
        S_FETCHD: begin
          eout  <= rd_data;
          state <= (mode == M_NONE) ? S_OUT : S_SHRD;
        end
        S_SHRD: begin
          state <= (ptr == stop) ? S_OUT : S_SHWR;
        end
        S_SHWR: begin
          ptr   <= (mode == M_UP) ? ptr - CW'(1) : ptr + CW'(1);
          state <= S_SHRD;
        end
        S_OUT: begin
          if (out_free) begin
            rsp.status       <= status;
            rsp.result_index <= 7'(ridx);
            rsp.entry_out    <= wide_out[31:0];
            rsp.count_out    <= 7'(count);
            rsp.is_empty     <= empty;
            rsp_valid        <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/indexed_shift_array_deque_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_shift_array_deque_core_tb
// Self-checking bench for the indexed shift-array deque. A driver offers
// queued requests and a monitor checks every result against a shadow list
// kept in the bench. The run moves through several idle/stall mixes and
// includes one long output hold that backs the core up into its input.
// ----------------------------------------------------------------------------
module indexed_shift_array_deque_core_tb;

  localparam int LIST_DEPTH  = isad_pkg::DEF_CAPACITY;
  localparam int RAND_ITEMS  = 1150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 200;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_stall = 1'b0;
  isad_pkg::req_t req = '0;
  logic req_stall;
  logic rsp_valid;
  isad_pkg::rsp_t rsp;

  indexed_shift_array_deque_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the list
  logic [31:0] list_mem [LIST_DEPTH];
  int          list_count = 0;

  isad_pkg::req_t pending_reqs [$];
  isad_pkg::rsp_t expected_rsps [$];
  int   queued_total   = 0;
  int   accepted_total = 0;
  int   op_items       = 0;
  int   err_count      = 0;
  logic req_taken      = 1'b0;
  int   send_idle_pct  = 0;
  int   stall_pct      = 0;
  int   hold_token     = 0;
  int   hold_seen      = 0;
  int   hold_left      = 0;

  function automatic isad_pkg::rsp_t deque_apply(isad_pkg::req_t r);
    isad_pkg::rsp_t o;
    int   pos;
    logic full_now;
    logic empty_now;
    o         = '0;
    pos       = int'(r.position);
    full_now  = list_count >= LIST_DEPTH;
    empty_now = list_count == 0;
    case (r.req_type)
      isad_pkg::REQ_GET: begin
        if (pos < list_count) begin
          o.result_index = r.position;
          o.entry_out    = list_mem[pos];
        end else begin
          o.status = isad_pkg::ST_BADIDX;
        end
      end
      isad_pkg::REQ_SET: begin
        if (pos < list_count) begin
          list_mem[pos]  = r.entry_in;
          o.result_index = r.position;
        end else begin
          o.status = isad_pkg::ST_BADIDX;
        end
      end
      isad_pkg::REQ_INSERT: begin
        if (pos > list_count) begin
          o.status = isad_pkg::ST_BADIDX;
        end else if (full_now) begin
          o.status = isad_pkg::ST_FULL;
        end else begin
          for (int i = list_count; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos]  = r.entry_in;
          list_count++;
          o.result_index = r.position;
        end
      end
      isad_pkg::REQ_REMOVE: begin
        if (pos < list_count) begin
          for (int i = pos; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
          o.result_index = r.position;
        end else begin
          o.status = isad_pkg::ST_BADIDX;
        end
      end
      isad_pkg::REQ_PUSH_BACK: begin
        if (full_now) begin
          o.status = isad_pkg::ST_FULL;
        end else begin
          o.result_index       = 7'(list_count);
          list_mem[list_count] = r.entry_in;
          list_count++;
        end
      end
      isad_pkg::REQ_PUSH_FRONT: begin
        if (full_now) begin
          o.status = isad_pkg::ST_FULL;
        end else begin
          for (int i = list_count; i > 0; i--) list_mem[i] = list_mem[i-1];
          list_mem[0] = r.entry_in;
          list_count++;
        end
      end
      isad_pkg::REQ_POP_FRONT: begin
        if (empty_now) begin
          o.status = isad_pkg::ST_EMPTY;
        end else begin
          o.entry_out = list_mem[0];
          for (int i = 0; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
          list_count--;
        end
      end
      isad_pkg::REQ_POP_BACK: begin
        if (empty_now) begin
          o.status = isad_pkg::ST_EMPTY;
        end else begin
          o.result_index = 7'(list_count - 1);
          o.entry_out    = list_mem[list_count-1];
          list_count--;
        end
      end
      isad_pkg::REQ_LOOK_FRONT: begin
        if (empty_now) o.status = isad_pkg::ST_EMPTY;
        else o.entry_out = list_mem[0];
      end
      isad_pkg::REQ_LOOK_BACK: begin
        if (empty_now) begin
          o.status = isad_pkg::ST_EMPTY;
        end else begin
          o.result_index = 7'(list_count - 1);
          o.entry_out    = list_mem[list_count-1];
        end
      end
      default: begin
      end
    endcase
    o.count_out = 7'(list_count);
    o.is_empty  = list_count == 0;
    return o;
  endfunction

  // driver: offer at the falling edge, hold until the transfer completes
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  // monitor: check results, then predict the request taken at this edge
  always @(posedge clk) begin
    isad_pkg::rsp_t want;
    req_taken <= !rst && req_valid && !req_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("result with no request outstanding: %p", rsp);
        err_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          err_count++;
        end
        if (rsp.result_index !== want.result_index) begin
          $error("result_index: expected %0d, got %0d", want.result_index, rsp.result_index);
          err_count++;
        end
        if (rsp.entry_out !== want.entry_out) begin
          $error("entry_out: expected %h, got %h", want.entry_out, rsp.entry_out);
          err_count++;
        end
        if (rsp.count_out !== want.count_out) begin
          $error("count_out: expected %0d, got %0d", want.count_out, rsp.count_out);
          err_count++;
        end
        if (rsp.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, rsp.is_empty);
          err_count++;
        end
      end
    end
    if (!rst && req_valid && !req_stall) begin
      expected_rsps.push_back(deque_apply(req));
      accepted_total <= accepted_total + 1;
    end
  end

  task automatic queue_item(input logic [3:0] kind, input int pos, input logic [31:0] val);
    pending_reqs.push_back(
      isad_pkg::req_t'{req_type: kind, position: 7'(pos), entry_in: val});
    queued_total++;
    if (kind <= isad_pkg::REQ_LOOK_BACK) op_items++;
  endtask

  task automatic wait_caught_up;
    while (accepted_total != queued_total) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_entry;
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int idle_plan [5];
    int stall_plan [5];
    int cur_phase;
    int phase;
    int est;
    int n;
    int sel;
    int seq_kind;
    logic first_seq;
    idle_plan  = '{0, 52, 0, 36, 0};
    stall_plan = '{0, 0, 52, 36, 0};
    cur_phase  = 0;
    first_seq  = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty list, bounds, both ends, extremes of the fields
    queue_item(isad_pkg::REQ_GET, 0, 32'h0);
    queue_item(isad_pkg::REQ_REMOVE, 0, 32'h0);
    queue_item(isad_pkg::REQ_POP_FRONT, 0, 32'h0);
    queue_item(isad_pkg::REQ_POP_BACK, 0, 32'h0);
    queue_item(isad_pkg::REQ_LOOK_FRONT, 0, 32'h0);
    queue_item(isad_pkg::REQ_LOOK_BACK, 127, 32'hFFFF_FFFF);
    queue_item(isad_pkg::REQ_SET, 0, 32'hDEAD_BEEF);
    queue_item(isad_pkg::REQ_INSERT, 1, 32'h1111_1111);
    queue_item(isad_pkg::REQ_PUSH_FRONT, 0, 32'hFFFF_FFFF);
    queue_item(isad_pkg::REQ_PUSH_BACK, 127, 32'h0000_0000);
    queue_item(isad_pkg::REQ_INSERT, 2, 32'hA5A5_A5A5);
    queue_item(isad_pkg::REQ_INSERT, 0, 32'h5A5A_5A5A);
    queue_item(isad_pkg::REQ_INSERT, 127, 32'h7777_7777);
    queue_item(isad_pkg::REQ_GET, 3, 32'h0);
    queue_item(isad_pkg::REQ_GET, 4, 32'h0);
    queue_item(isad_pkg::REQ_SET, 1, 32'h1234_5678);
    queue_item(isad_pkg::REQ_LOOK_FRONT, 0, 32'h0);
    queue_item(isad_pkg::REQ_LOOK_BACK, 0, 32'h0);
    queue_item(isad_pkg::REQ_REMOVE, 1, 32'h0);
    queue_item(isad_pkg::REQ_REMOVE, 3, 32'h0);
    queue_item(isad_pkg::REQ_POP_FRONT, 0, 32'h0);
    queue_item(isad_pkg::REQ_POP_BACK, 0, 32'h0);
    queue_item(4'd10, 127, 32'hFFFF_FFFF);
    queue_item(4'd15, 0, 32'h0);
    op_items = 0;

    while (op_items < RAND_ITEMS) begin
      wait_caught_up();
      seq_kind = $urandom_range(0, 9);
      phase    = op_items * 5 / RAND_ITEMS;
      if (phase != cur_phase) begin
        cur_phase     = phase;
        send_idle_pct = idle_plan[phase];
        stall_pct     = stall_plan[phase];
        if (phase == 4) begin
          hold_token++;
          seq_kind = 5;
        end
      end
      if (first_seq) seq_kind = 0;
      first_seq = 1'b0;
      est = list_count;
      if (seq_kind <= 1) begin
        // fill past full
        n = LIST_DEPTH - est + $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          sel = $urandom_range(0, 2);
          if (sel == 0)
            queue_item(isad_pkg::REQ_PUSH_BACK, $urandom_range(0, 127), pick_entry());
          else if (sel == 1)
            queue_item(isad_pkg::REQ_PUSH_FRONT, $urandom_range(0, 127), pick_entry());
          else if (est < LIST_DEPTH)
            queue_item(isad_pkg::REQ_INSERT, $urandom_range(0, est), pick_entry());
          else
            queue_item(isad_pkg::REQ_INSERT, $urandom_range(0, LIST_DEPTH + 1),
                       pick_entry());
          if (est < LIST_DEPTH) est++;
        end
      end else if (seq_kind <= 3) begin
        // drain past empty
        n = est + $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          sel = $urandom_range(0, 3);
          if (sel == 0)
            queue_item(isad_pkg::REQ_POP_FRONT, $urandom_range(0, 127), pick_entry());
          else if (sel == 1)
            queue_item(isad_pkg::REQ_POP_BACK, $urandom_range(0, 127), pick_entry());
          else if (sel == 2 && est > 0)
            queue_item(isad_pkg::REQ_REMOVE, $urandom_range(0, est - 1), 32'h0);
          else if (est > 0)
            queue_item(isad_pkg::REQ_REMOVE, 0, pick_entry());
          else
            queue_item(sel == 2 ? isad_pkg::REQ_LOOK_FRONT : isad_pkg::REQ_LOOK_BACK,
                       0, 32'h0);
          if (est > 0) est--;
        end
      end else if (seq_kind <= 8) begin
        n = $urandom_range(10, 40);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 99) < 85)
            queue_item(4'($urandom_range(0, 9)), $urandom_range(0, est + 1), pick_entry());
          else
            queue_item(4'($urandom_range(0, 9)), $urandom_range(0, 127), pick_entry());
        end
      end else begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
          queue_item(4'($urandom_range(10, 15)), $urandom_range(0, 127), $urandom);
      end
    end

    wait_caught_up();
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL");
    $finish;
  end

endmodule
